// File: rtl/tlcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_pkg
// Shared widths, register indexes and controller/datapath command types for
// the straight-line track chi-square block.
// ----------------------------------------------------------------------------
package tlcs_pkg;

  localparam int DATA_W    = 32;
  localparam int SUM_W     = 48;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int WIDE_W    = 66;
  localparam int SQ_HALF   = 24;
  localparam int ACC_W     = 96;
  localparam int NUM_W     = 128;
  localparam int DEN_W     = 64;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int LAYER_W   = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_X0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_Y0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_Z      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_LAYER = 3'd5;

  localparam logic [LAYER_W-1:0] SKIP_RESET = 4'd15;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_PREP,
    OP_MUL_TX,
    OP_MUL_TY,
    OP_MUL_ERR,
    OP_CHECK,
    OP_MUL_LA,
    OP_DEN,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_DIV1,
    OP_DIV2,
    OP_WAIT,
    OP_SAT,
    OP_TERM,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic counted;
    logic err_zero;
    logic inclined;
    logic proj_ovf;
    logic res_ovf;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/tlcs_hit_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_hit_if
// Layer hit channel: valid/ready handshake with one layer description.
// ----------------------------------------------------------------------------
interface tlcs_hit_if;
  logic                valid;
  logic                ready;
  logic [3:0]          layer_index;
  logic                is_inclined;
  logic signed [31:0]  layer_z;
  logic signed [31:0]  measured_x;
  logic signed [31:0]  line_slope;
  logic signed [31:0]  line_offset;
  logic signed [31:0]  hit_error;
  logic                last_layer;

  modport source (output valid, layer_index, is_inclined, layer_z, measured_x,
                  line_slope, line_offset, hit_error, last_layer, input ready);
  modport sink (input valid, layer_index, is_inclined, layer_z, measured_x,
                line_slope, line_offset, hit_error, last_layer, output ready);
endinterface

// File: rtl/tlcs_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_result_if
// Result channel: valid/ready handshake with the running sum and flags.
// ----------------------------------------------------------------------------
interface tlcs_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] chi_square_sum;
  logic        zero_error_seen;
  logic        sum_saturated;
  logic        track_done;

  modport source (output valid, chi_square_sum, zero_error_seen, sum_saturated,
                  track_done, input ready);
  modport sink (input valid, chi_square_sum, zero_error_seen, sum_saturated,
                track_done, output ready);
endinterface

// File: rtl/tlcs_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface tlcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/tlcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_div
// Restoring divider, 128-bit dividend by 64-bit divisor, one quotient bit
// per cycle. done pulses for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module tlcs_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tlcs_pkg::NUM_W-1:0]    num,
  input  logic [tlcs_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [tlcs_pkg::NUM_W-1:0]    quo
);

  logic                          busy;
  logic [tlcs_pkg::CNT_W-1:0]    cnt;
  logic [tlcs_pkg::NUM_W-1:0]    work;
  logic [tlcs_pkg::DEN_W-1:0]    rem;
  logic [tlcs_pkg::DEN_W-1:0]    dvs;
  logic [tlcs_pkg::DEN_W:0]      trial;
  logic [tlcs_pkg::DEN_W+1:0]    diff;
  logic                          qbit;
  logic [tlcs_pkg::DEN_W-1:0]    rem_next;

  // The remainder stays below the divisor, so one extra bit holds the shift.
  assign trial    = {rem, work[tlcs_pkg::NUM_W-1]};
  assign diff     = {1'b0, trial} - {2'b00, dvs};
  assign qbit     = ~diff[tlcs_pkg::DEN_W+1];
  assign rem_next = qbit ? diff[tlcs_pkg::DEN_W-1:0] : trial[tlcs_pkg::DEN_W-1:0];
  assign quo      = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt  <= cnt + 1'b1;
        done <= (cnt == tlcs_pkg::CNT_W'(tlcs_pkg::NUM_W - 1));
        if (cnt == tlcs_pkg::CNT_W'(tlcs_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= num;
      rem  <= '0;
      dvs  <= den;
    end else if (busy) begin
      work <= {work[tlcs_pkg::NUM_W-2:0], qbit};
      rem  <= rem_next;
    end
  end

endmodule

// File: rtl/tlcs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_datapath
// Configuration registers, projection and residual arithmetic on one shared
// registered multiplier, the divider, the running sum and the result register.
// ----------------------------------------------------------------------------
module tlcs_datapath #(
  parameter int LAYER_COUNT   = 14,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlcs_pkg::cmd_t       cmd,
  output tlcs_pkg::sts_t       sts,
  tlcs_hit_if.sink             hit,
  tlcs_result_if.source        result,
  tlcs_cfg_if.sink             cfg
);

  localparam int W = tlcs_pkg::WIDE_W;
  localparam logic [W-1:0] HALF = W'(1) << (FRACTION_BITS - 1);
  localparam logic [tlcs_pkg::DEN_W-1:0] ONE_SQ =
    tlcs_pkg::DEN_W'(1) << (2 * FRACTION_BITS);

  // Configuration.
  logic signed [31:0] track_x0, track_y0, slope_x, slope_y, ref_z;
  logic [3:0]         skip_layer;

  // Latched item.
  logic [3:0]         layer_index;
  logic               is_inclined;
  logic signed [31:0] layer_z, measured_x, line_slope, line_offset, hit_error;
  logic               last_layer;

  // Working registers.
  logic signed [32:0]              t;
  logic [tlcs_pkg::PROD_W-1:0]     prod;
  logic signed [W-1:0]             px, py;
  logic [tlcs_pkg::DEN_W-1:0]      e2, den;
  logic [tlcs_pkg::SUM_W-1:0]      m;
  logic [tlcs_pkg::ACC_W-1:0]      acc;
  logic [tlcs_pkg::SUM_W-1:0]      term;
  logic                            term_sat;

  // Track state and result register.
  logic [tlcs_pkg::SUM_W-1:0]      running_sum;
  logic                            zero_error_flag, saturation_flag;
  logic                            out_valid;
  logic [tlcs_pkg::SUM_W-1:0]      out_sum;
  logic                            out_zero, out_sat, out_done;

  logic                            accept;
  logic [tlcs_pkg::MUL_W-1:0]      mul_a, mul_b;
  logic [tlcs_pkg::MUL_W-1:0]      t_mag, px_mag;
  logic [31:0]                     la_mag, err_mag;
  logic                            rnd_neg;
  logic [W-1:0]                    rnd_mag;
  logic signed [W-1:0]             rnd_val;
  logic signed [W-1:0]             res_d, xres;
  logic [W-1:0]                    res_mag, xres_mag, px_abs;
  logic                            px_fit, py_fit, d_fit;
  logic                            div_start, div_done;
  logic [tlcs_pkg::NUM_W-1:0]      div_num, div_quo, div_shift;
  logic [tlcs_pkg::DEN_W-1:0]      div_den;
  logic [tlcs_pkg::SUM_W:0]        sum_add;
  logic [tlcs_pkg::SUM_W-1:0]      sum_next;
  logic                            zflag_next, sflag_next, out_free;

  assign accept       = hit.valid && cmd.in_ready;
  assign hit.ready    = cmd.in_ready;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      track_x0   <= '0;
      track_y0   <= '0;
      slope_x    <= '0;
      slope_y    <= '0;
      ref_z      <= '0;
      skip_layer <= tlcs_pkg::SKIP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tlcs_pkg::REG_TRACK_X0:   track_x0   <= cfg.data;
        tlcs_pkg::REG_TRACK_Y0:   track_y0   <= cfg.data;
        tlcs_pkg::REG_SLOPE_X:    slope_x    <= cfg.data;
        tlcs_pkg::REG_SLOPE_Y:    slope_y    <= cfg.data;
        tlcs_pkg::REG_REF_Z:      ref_z      <= cfg.data;
        tlcs_pkg::REG_SKIP_LAYER: skip_layer <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  // Magnitudes feeding the multiplier.
  assign t_mag   = t[32] ? tlcs_pkg::MUL_W'(-t) : tlcs_pkg::MUL_W'(t);
  assign px_abs  = px[W-1] ? W'(-px) : W'(px);
  assign px_mag  = px_abs[tlcs_pkg::MUL_W-1:0];
  assign la_mag  = line_slope[31] ? 32'(-line_slope) : 32'(line_slope);
  assign err_mag = hit_error[31] ? 32'(-hit_error) : 32'(hit_error);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    rnd_neg = 1'b0;
    case (cmd.op)
      tlcs_pkg::OP_MUL_TX: begin
        mul_a = t_mag;
        mul_b = {1'b0, (slope_x[31] ? 32'(-slope_x) : 32'(slope_x))};
      end
      tlcs_pkg::OP_MUL_TY: begin
        mul_a   = t_mag;
        mul_b   = {1'b0, (slope_y[31] ? 32'(-slope_y) : 32'(slope_y))};
        rnd_neg = t[32] ^ slope_x[31];
      end
      tlcs_pkg::OP_MUL_ERR: begin
        mul_a   = {1'b0, err_mag};
        mul_b   = {1'b0, err_mag};
        rnd_neg = t[32] ^ slope_y[31];
      end
      tlcs_pkg::OP_CHECK: begin
        mul_a = px_mag;
        mul_b = {1'b0, la_mag};
      end
      tlcs_pkg::OP_MUL_LA: begin
        mul_a   = {1'b0, la_mag};
        mul_b   = {1'b0, la_mag};
        rnd_neg = line_slope[31] ^ px[W-1];
      end
      tlcs_pkg::OP_SQ0: begin
        mul_a = tlcs_pkg::MUL_W'(m[tlcs_pkg::SQ_HALF-1:0]);
        mul_b = tlcs_pkg::MUL_W'(m[tlcs_pkg::SQ_HALF-1:0]);
      end
      tlcs_pkg::OP_SQ1: begin
        mul_a = tlcs_pkg::MUL_W'(m[tlcs_pkg::SUM_W-1:tlcs_pkg::SQ_HALF]);
        mul_b = tlcs_pkg::MUL_W'(m[tlcs_pkg::SQ_HALF-1:0]);
      end
      tlcs_pkg::OP_SQ2: begin
        mul_a = tlcs_pkg::MUL_W'(m[tlcs_pkg::SUM_W-1:tlcs_pkg::SQ_HALF]);
        mul_b = tlcs_pkg::MUL_W'(m[tlcs_pkg::SUM_W-1:tlcs_pkg::SQ_HALF]);
      end
      default: ;
    endcase
  end

  // Round to nearest, ties away from zero, on the magnitude of the product.
  assign rnd_mag = (prod + HALF) >> FRACTION_BITS;
  assign rnd_val = rnd_neg ? -$signed(rnd_mag) : $signed(rnd_mag);

  assign px_fit  = (px[W-1:31] == '0) || (px[W-1:31] == '1);
  assign py_fit  = (py[W-1:31] == '0) || (py[W-1:31] == '1);
  assign res_d   = rnd_val - py + W'(line_offset);
  assign d_fit   = (res_d[W-1:47] == '0) || (res_d[W-1:47] == '1);
  assign res_mag = res_d[W-1] ? W'(-res_d) : W'(res_d);
  assign xres    = W'(measured_x) - px;
  assign xres_mag = xres[W-1] ? W'(-xres) : W'(xres);

  assign div_start = (cmd.op == tlcs_pkg::OP_DIV1) || (cmd.op == tlcs_pkg::OP_DIV2);
  assign div_shift = div_quo << (2 * FRACTION_BITS);
  assign div_num   = (cmd.op == tlcs_pkg::OP_DIV2) ? div_shift
                   : tlcs_pkg::NUM_W'(acc) << FRACTION_BITS;
  assign div_den   = (cmd.op == tlcs_pkg::OP_DIV1 && is_inclined) ? den : e2;

  tlcs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      layer_index <= hit.layer_index;
      is_inclined <= hit.is_inclined;
      layer_z     <= hit.layer_z;
      measured_x  <= hit.measured_x;
      line_slope  <= hit.line_slope;
      line_offset <= hit.line_offset;
      hit_error   <= hit.hit_error;
      last_layer  <= hit.last_layer;
    end
    prod <= mul_a * mul_b;
    case (cmd.op)
      tlcs_pkg::OP_PREP:    t  <= 33'(layer_z) - 33'(ref_z);
      tlcs_pkg::OP_MUL_TY:  px <= W'(track_x0) + rnd_val;
      tlcs_pkg::OP_MUL_ERR: py <= W'(track_y0) + rnd_val;
      tlcs_pkg::OP_CHECK: begin
        e2 <= prod[tlcs_pkg::DEN_W-1:0];
        m  <= xres_mag[tlcs_pkg::SUM_W-1:0];
      end
      tlcs_pkg::OP_MUL_LA:  m   <= res_mag[tlcs_pkg::SUM_W-1:0];
      tlcs_pkg::OP_DEN:     den <= prod[tlcs_pkg::DEN_W-1:0] + ONE_SQ;
      tlcs_pkg::OP_SQ1:     acc <= tlcs_pkg::ACC_W'(prod);
      tlcs_pkg::OP_SQ2:     acc <= acc + (tlcs_pkg::ACC_W'(prod) << (tlcs_pkg::SQ_HALF + 1));
      tlcs_pkg::OP_SQ3:     acc <= acc + (tlcs_pkg::ACC_W'(prod) << (2 * tlcs_pkg::SQ_HALF));
      tlcs_pkg::OP_SAT: begin
        term     <= tlcs_pkg::SUM_MAX;
        term_sat <= 1'b1;
      end
      tlcs_pkg::OP_TERM: begin
        if (div_quo[tlcs_pkg::NUM_W-1:tlcs_pkg::SUM_W] != '0) begin
          term     <= tlcs_pkg::SUM_MAX;
          term_sat <= 1'b1;
        end else begin
          term     <= div_quo[tlcs_pkg::SUM_W-1:0];
          term_sat <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Sum update for the finishing item.
  assign sum_add = {1'b0, running_sum} + {1'b0, term};
  assign out_free = !out_valid || result.ready;

  always_comb begin
    sum_next   = running_sum;
    zflag_next = zero_error_flag;
    sflag_next = saturation_flag;
    if (sts.counted && sts.err_zero) begin
      zflag_next = 1'b1;
    end else if (sts.counted) begin
      if (sum_add[tlcs_pkg::SUM_W]) begin
        sum_next   = tlcs_pkg::SUM_MAX;
        sflag_next = 1'b1;
      end else begin
        sum_next = sum_add[tlcs_pkg::SUM_W-1:0];
      end
      if (term_sat) begin
        sflag_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum     <= '0;
      zero_error_flag <= 1'b0;
      saturation_flag <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.op == tlcs_pkg::OP_FIN && out_free) begin
        out_valid <= 1'b1;
        if (last_layer) begin
          running_sum     <= '0;
          zero_error_flag <= 1'b0;
          saturation_flag <= 1'b0;
        end else begin
          running_sum     <= sum_next;
          zero_error_flag <= zflag_next;
          saturation_flag <= sflag_next;
        end
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == tlcs_pkg::OP_FIN && out_free) begin
      out_sum  <= sum_next;
      out_zero <= zflag_next;
      out_sat  <= sflag_next;
      out_done <= last_layer;
    end
  end

  assign result.valid           = out_valid;
  assign result.chi_square_sum  = out_sum;
  assign result.zero_error_seen = out_zero;
  assign result.sum_saturated   = out_sat;
  assign result.track_done      = out_done;

  assign sts.counted  = ({1'b0, layer_index} < 5'(LAYER_COUNT)) &&
                        !(({1'b0, skip_layer} < 5'(LAYER_COUNT)) &&
                          (layer_index == skip_layer));
  assign sts.err_zero = (hit_error == '0);
  assign sts.inclined = is_inclined;
  assign sts.proj_ovf = !px_fit || (is_inclined && !py_fit);
  assign sts.res_ovf  = !d_fit;
  assign sts.div_done = div_done;
  assign sts.out_free = out_free;

endmodule

// File: rtl/tlcs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcs_ctrl
// Sequencer that steps one layer item through projection, residual,
// squaring, one or two divisions and the sum update, or saturates or skips it.
// ----------------------------------------------------------------------------
module tlcs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            hit_valid,
  input  tlcs_pkg::sts_t  sts,
  output tlcs_pkg::cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_MTX, S_MTY, S_MERR, S_CHECK, S_MLA, S_DEN,
    S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_DIV1, S_DW1, S_DIV2, S_DW2,
    S_SAT, S_TERM, S_FIN
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cmd.op       <= tlcs_pkg::OP_IDLE;
      cmd.in_ready <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (hit_valid && cmd.in_ready) begin
            state        <= S_PREP;
            cmd.op       <= tlcs_pkg::OP_PREP;
            cmd.in_ready <= 1'b0;
          end
        end
        S_PREP: begin
          if (!sts.counted || sts.err_zero) begin
            state  <= S_FIN;
            cmd.op <= tlcs_pkg::OP_FIN;
          end else begin
            state  <= S_MTX;
            cmd.op <= tlcs_pkg::OP_MUL_TX;
          end
        end
        S_MTX: begin
          state  <= S_MTY;
          cmd.op <= tlcs_pkg::OP_MUL_TY;
        end
        S_MTY: begin
          state  <= S_MERR;
          cmd.op <= tlcs_pkg::OP_MUL_ERR;
        end
        S_MERR: begin
          state  <= S_CHECK;
          cmd.op <= tlcs_pkg::OP_CHECK;
        end
        S_CHECK: begin
          if (sts.proj_ovf) begin
            state  <= S_SAT;
            cmd.op <= tlcs_pkg::OP_SAT;
          end else if (sts.inclined) begin
            state  <= S_MLA;
            cmd.op <= tlcs_pkg::OP_MUL_LA;
          end else begin
            state  <= S_SQ0;
            cmd.op <= tlcs_pkg::OP_SQ0;
          end
        end
        S_MLA: begin
          if (sts.res_ovf) begin
            state  <= S_SAT;
            cmd.op <= tlcs_pkg::OP_SAT;
          end else begin
            state  <= S_DEN;
            cmd.op <= tlcs_pkg::OP_DEN;
          end
        end
        S_DEN: begin
          state  <= S_SQ0;
          cmd.op <= tlcs_pkg::OP_SQ0;
        end
        S_SQ0: begin
          state  <= S_SQ1;
          cmd.op <= tlcs_pkg::OP_SQ1;
        end
        S_SQ1: begin
          state  <= S_SQ2;
          cmd.op <= tlcs_pkg::OP_SQ2;
        end
        S_SQ2: begin
          state  <= S_SQ3;
          cmd.op <= tlcs_pkg::OP_SQ3;
        end
        S_SQ3: begin
          state  <= S_DIV1;
          cmd.op <= tlcs_pkg::OP_DIV1;
        end
        S_DIV1: begin
          state  <= S_DW1;
          cmd.op <= tlcs_pkg::OP_WAIT;
        end
        S_DW1: begin
          if (sts.div_done) begin
            if (sts.inclined) begin
              state  <= S_DIV2;
              cmd.op <= tlcs_pkg::OP_DIV2;
            end else begin
              state  <= S_TERM;
              cmd.op <= tlcs_pkg::OP_TERM;
            end
          end
        end
        S_DIV2: begin
          state  <= S_DW2;
          cmd.op <= tlcs_pkg::OP_WAIT;
        end
        S_DW2: begin
          if (sts.div_done) begin
            state  <= S_TERM;
            cmd.op <= tlcs_pkg::OP_TERM;
          end
        end
        S_SAT, S_TERM: begin
          state  <= S_FIN;
          cmd.op <= tlcs_pkg::OP_FIN;
        end
        S_FIN: begin
          // The datapath commits the sum in the same cycle the result slot frees.
          if (sts.out_free) begin
            state        <= S_IDLE;
            cmd.op       <= tlcs_pkg::OP_IDLE;
            cmd.in_ready <= 1'b1;
          end
        end
        default: begin
          state        <= S_IDLE;
          cmd.op       <= tlcs_pkg::OP_IDLE;
          cmd.in_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

// File: rtl/track_line_chi_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// track_line_chi_square
// Straight-track chi-square accumulator, one detector layer per item.
// ----------------------------------------------------------------------------
// One layer item is processed at a time. A skipped, out-of-range or
// zero-error layer goes straight to the result update; a straight layer runs
// one division and an inclined layer two chained ones on the restoring
// divider, which produces one quotient bit per cycle over a 128-bit
// dividend. A new item is taken once the previous result has been placed
// in the output register, even if that result has not yet been read.
// Configuration writes are taken in any cycle and must only be issued
// while no item is in flight.
module track_line_chi_square #(
  parameter int LAYER_COUNT   = 14,
  parameter int FRACTION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  tlcs_hit_if.sink      hit,
  tlcs_result_if.source result,
  tlcs_cfg_if.sink      cfg
);

  tlcs_pkg::cmd_t cmd;
  tlcs_pkg::sts_t sts;

  tlcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .hit_valid (hit.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  tlcs_datapath #(
    .LAYER_COUNT   (LAYER_COUNT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .hit    (hit),
    .result (result),
    .cfg    (cfg)
  );

endmodule
